@@ rtl/squad_pkg.sv @@
// Shared types, widths and constant tables for the sprite quad transform.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package squad_pkg;

  // fraction bits of sine and cosine
  localparam int TRIG_BITS  = 16;
  localparam int TRIG_SHIFT = 30 - TRIG_BITS;
  localparam int TRIG_W     = TRIG_BITS + 2;
  localparam int TRIG_MAG_W = TRIG_BITS + 1;

  // field widths
  localparam int COORD_W   = 24;
  localparam int SIZE_W    = 23;
  localparam int SCALE_W   = 16;
  localparam int ANGLE_W   = 15;
  localparam int UV_W      = 16;
  localparam int CFG_IDX_W = 2;

  // datapath widths
  localparam int SCALED_W  = COORD_W + SCALE_W;
  localparam int GEO_W     = SCALED_W - 8 + 1;
  localparam int PROD_W    = GEO_W + TRIG_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int ROT_W     = SUM_W - TRIG_BITS;
  localparam int POS_SUM_W = ROT_W + 1;

  // angle reduction, radians in Q30
  localparam int QUAD_UNITS = 5760;
  localparam int REM_W      = 13;
  localparam int PI_HI      = 292817;
  localparam int PI_LO      = 7586;
  localparam int RECIP_45   = 372827;
  localparam int X_W        = 31;
  localparam logic [X_W-1:0] Q30_ONE = X_W'(32'h4000_0000);

  // taylor series in horner form
  localparam int HORNER_STEPS = 6;
  localparam int HORNER_LAT   = 4 * HORNER_STEPS;
  localparam logic [7:0] SIN_DIV [HORNER_STEPS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [7:0] COS_DIV [HORNER_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [31:0] SIN_RECIP [HORNER_STEPS] = '{
    32'd27531841, 32'd39045157, 32'd59652323, 32'd102261126, 32'd214748364, 32'd715827882};
  localparam logic [31:0] COS_RECIP [HORNER_STEPS] = '{
    32'd32537631, 32'd47721858, 32'd76695844, 32'd143165576, 32'd357913941, 32'd2147483648};

  // queues
  localparam int QDEPTH = 16;
  localparam int QPTR_W = 4;
  localparam int QCNT_W = 5;
  localparam int RDEPTH = 8;
  localparam int RPTR_W = 3;
  localparam int RCNT_W = 4;

  // corner codes
  localparam logic [1:0] CORNER_FIRST = 2'd0;
  localparam logic [1:0] CORNER_LAST  = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_U_LEFT   = 2'd0,
    REG_V_TOP    = 2'd1,
    REG_U_RIGHT  = 2'd2,
    REG_V_BOTTOM = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [UV_W-1:0] u_left;
    logic [UV_W-1:0] v_top;
    logic [UV_W-1:0] u_right;
    logic [UV_W-1:0] v_bottom;
  } region_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [GEO_W-1:0]   cx0;
    logic signed [GEO_W-1:0]   cx1;
    logic signed [GEO_W-1:0]   cy0;
    logic signed [GEO_W-1:0]   cy1;
    logic signed [TRIG_W-1:0]  sin_v;
    logic signed [TRIG_W-1:0]  cos_v;
  } item_t;

  typedef struct packed {
    logic [1:0]                corner;
    logic signed [COORD_W-1:0] vert_x;
    logic signed [COORD_W-1:0] vert_y;
    logic [UV_W-1:0]           tex_u;
    logic [UV_W-1:0]           tex_v;
    logic                      last_vertex;
  } result_t;

endpackage

@@ rtl/sprite_quad_transform.sv @@
// Sprite quad vertex transform, top level with region registers and credits.
// Depends on squad_pkg, squad_front, squad_item_fifo and squad_back.
//
// Usage:
//   Sprite words enter through push/full: one word is taken at each rising
//   edge with push high and full low. A word with texture_valid low is taken
//   and gives no vertices. Each other word gives four vertex words, corners
//   0 to 3, on the result side: a word waits on the ports while empty is
//   low and leaves at an edge with pop high.
//   The region registers are written through cfg_we, cfg_index, cfg_data
//   and take effect at the next edge; write them only while the block idles.
//   Path: a sprite passes the trig pipeline, the sprite queue and the corner
//   unit before its first vertex shows.
//   Throughput: a new sprite every cycle is taken until sixteen are in
//   flight; corner unit vertices leave at one per cycle while the result
//   queue has room; its single rotate and add datapath sets the sprite rate.
//   Reset (rst, synchronous) empties both queues and loads the region with
//   u 0..1 and v 0..1. When pop stays low the result queue fills, the
//   corner unit stops, the sprite queue fills and full rises.
`timescale 1ns / 1ps

module sprite_quad_transform (
  input  logic                                   clk,
  input  logic                                   rst,
  // sprite channel
  input  logic                                   push,
  output logic                                   full,
  input  logic                                   texture_valid,
  input  logic signed [squad_pkg::COORD_W-1:0]   pos_x,
  input  logic signed [squad_pkg::COORD_W-1:0]   pos_y,
  input  logic [squad_pkg::SIZE_W-1:0]           size_w,
  input  logic [squad_pkg::SIZE_W-1:0]           size_h,
  input  logic signed [squad_pkg::SCALE_W-1:0]   scale_x,
  input  logic signed [squad_pkg::SCALE_W-1:0]   scale_y,
  input  logic signed [squad_pkg::COORD_W-1:0]   origin_x,
  input  logic signed [squad_pkg::COORD_W-1:0]   origin_y,
  input  logic [squad_pkg::ANGLE_W-1:0]          angle_deg,
  // vertex channel
  output logic                                   empty,
  input  logic                                   pop,
  output logic [1:0]                             corner,
  output logic signed [squad_pkg::COORD_W-1:0]   vert_x,
  output logic signed [squad_pkg::COORD_W-1:0]   vert_y,
  output logic [squad_pkg::UV_W-1:0]             tex_u,
  output logic [squad_pkg::UV_W-1:0]             tex_v,
  output logic                                   last_vertex,
  // register port
  input  logic                                   cfg_we,
  input  logic [squad_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [squad_pkg::UV_W-1:0]             cfg_data
);

  squad_pkg::region_t              region;
  logic [squad_pkg::QCNT_W-1:0]    used;
  logic                            take;
  logic                            item_vld_f;
  squad_pkg::item_t                item_f;
  logic                            item_vld_q;
  squad_pkg::item_t                item_q;
  logic                            item_pop;
  squad_pkg::result_t              res;

  // region registers
  always_ff @(posedge clk) begin
    if (rst) begin
      region.u_left   <= '0;
      region.v_top    <= '0;
      region.u_right  <= squad_pkg::UV_W'(32768);
      region.v_bottom <= squad_pkg::UV_W'(32768);
    end else if (cfg_we) begin
      unique case (squad_pkg::cfg_reg_t'(cfg_index))
        squad_pkg::REG_U_LEFT:   region.u_left   <= cfg_data;
        squad_pkg::REG_V_TOP:    region.v_top    <= cfg_data;
        squad_pkg::REG_U_RIGHT:  region.u_right  <= cfg_data;
        squad_pkg::REG_V_BOTTOM: region.v_bottom <= cfg_data;
      endcase
    end
  end

  // sprite credits: pipeline plus queue never exceed the queue depth
  assign full = (used == squad_pkg::QCNT_W'(squad_pkg::QDEPTH));
  assign take = push && !full && texture_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used + squad_pkg::QCNT_W'(take) - squad_pkg::QCNT_W'(item_pop);
    end
  end

  squad_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .size_w    (size_w),
    .size_h    (size_h),
    .scale_x   (scale_x),
    .scale_y   (scale_y),
    .origin_x  (origin_x),
    .origin_y  (origin_y),
    .angle_deg (angle_deg),
    .item_vld  (item_vld_f),
    .item      (item_f)
  );

  squad_item_fifo u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (item_vld_f),
    .wr_item (item_f),
    .rd_en   (item_pop),
    .rd_vld  (item_vld_q),
    .rd_item (item_q)
  );

  squad_back u_back (
    .clk       (clk),
    .rst       (rst),
    .region    (region),
    .item_vld  (item_vld_q),
    .item      (item_q),
    .item_pop  (item_pop),
    .res_pop   (pop),
    .res_empty (empty),
    .res       (res)
  );

  assign corner      = res.corner;
  assign vert_x      = res.vert_x;
  assign vert_y      = res.vert_y;
  assign tex_u       = res.tex_u;
  assign tex_v       = res.tex_v;
  assign last_vertex = res.last_vertex;

endmodule

@@ rtl/squad_horner.sv @@
// One taylor lane (sine or cosine polynomial) as a pipeline of horner steps.
// Depends on squad_pkg for the divisor and reciprocal tables.
`timescale 1ns / 1ps

module squad_horner (
  input  logic                          clk,
  input  logic                          lane_cos,
  input  logic [31:0]                   x2,
  output logic [squad_pkg::X_W-1:0]     t_out
);

  logic [31:0]                  x2_in [squad_pkg::HORNER_STEPS];
  logic [squad_pkg::X_W-1:0]    t_in  [squad_pkg::HORNER_STEPS];
  logic [31:0]                  x2_a  [squad_pkg::HORNER_STEPS];
  logic [31:0]                  x2_b  [squad_pkg::HORNER_STEPS];
  logic [31:0]                  x2_c  [squad_pkg::HORNER_STEPS];
  logic [31:0]                  x2_d  [squad_pkg::HORNER_STEPS];
  logic [31:0]                  p_a   [squad_pkg::HORNER_STEPS];
  logic [31:0]                  p_b   [squad_pkg::HORNER_STEPS];
  logic [63:0]                  m_b   [squad_pkg::HORNER_STEPS];
  logic [31:0]                  dq_c  [squad_pkg::HORNER_STEPS];
  logic [squad_pkg::X_W-1:0]    t_d   [squad_pkg::HORNER_STEPS];

  for (genvar i = 0; i < squad_pkg::HORNER_STEPS; i++) begin : g_step
    logic [7:0]  dv;
    logic [31:0] rc;
    logic [62:0] prod;
    logic [31:0] q0;
    logic [39:0] rem;

    assign dv = lane_cos ? squad_pkg::COS_DIV[i] : squad_pkg::SIN_DIV[i];
    assign rc = lane_cos ? squad_pkg::COS_RECIP[i] : squad_pkg::SIN_RECIP[i];

    // chain input: first step starts from one
    if (i == 0) begin : g_first
      assign x2_in[i] = x2;
      assign t_in[i]  = squad_pkg::Q30_ONE;
    end else begin : g_next
      assign x2_in[i] = x2_d[i-1];
      assign t_in[i]  = t_d[i-1];
    end

    // x2 times t, back to q30
    assign prod = 63'(x2_in[i]) * 63'(t_in[i]);
    always_ff @(posedge clk) begin
      p_a[i]  <= prod[61:30];
      x2_a[i] <= x2_in[i];
    end

    // quotient estimate by reciprocal
    always_ff @(posedge clk) begin
      m_b[i]  <= 64'(p_a[i]) * 64'(rc);
      p_b[i]  <= p_a[i];
      x2_b[i] <= x2_a[i];
    end

    // one step of correction on the quotient
    assign q0  = m_b[i][63:32];
    assign rem = 40'(p_b[i]) - 40'(q0) * 40'(dv);
    always_ff @(posedge clk) begin
      dq_c[i] <= (rem >= 40'(dv)) ? q0 + 32'd1 : q0;
      x2_c[i] <= x2_b[i];
    end

    // one minus quotient, floored at zero
    always_ff @(posedge clk) begin
      t_d[i]  <= (dq_c[i] >= 32'(squad_pkg::Q30_ONE)) ? '0
               : squad_pkg::Q30_ONE - dq_c[i][squad_pkg::X_W-1:0];
      x2_d[i] <= x2_c[i];
    end
  end

  assign t_out = t_d[squad_pkg::HORNER_STEPS-1];

endmodule

@@ rtl/squad_front.sv @@
// Front pipeline: scales the quad geometry, reduces the angle and forms sine
// and cosine. Depends on squad_pkg and squad_horner.
`timescale 1ns / 1ps

module squad_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   take,
  input  logic signed [squad_pkg::COORD_W-1:0]   pos_x,
  input  logic signed [squad_pkg::COORD_W-1:0]   pos_y,
  input  logic [squad_pkg::SIZE_W-1:0]           size_w,
  input  logic [squad_pkg::SIZE_W-1:0]           size_h,
  input  logic signed [squad_pkg::SCALE_W-1:0]   scale_x,
  input  logic signed [squad_pkg::SCALE_W-1:0]   scale_y,
  input  logic signed [squad_pkg::COORD_W-1:0]   origin_x,
  input  logic signed [squad_pkg::COORD_W-1:0]   origin_y,
  input  logic [squad_pkg::ANGLE_W-1:0]          angle_deg,
  output logic                                   item_vld,
  output squad_pkg::item_t                       item
);

  typedef struct packed {
    logic [1:0]                             quad;
    logic signed [squad_pkg::COORD_W-1:0]   pos_x;
    logic signed [squad_pkg::COORD_W-1:0]   pos_y;
    logic signed [squad_pkg::GEO_W-1:0]     cx0;
    logic signed [squad_pkg::GEO_W-1:0]     cx1;
    logic signed [squad_pkg::GEO_W-1:0]     cy0;
    logic signed [squad_pkg::GEO_W-1:0]     cy1;
  } geo_t;

  typedef struct packed {
    geo_t                        geo;
    logic [squad_pkg::X_W-1:0]   x;
  } side_t;

  // valid bits along the pipe
  logic [6:0]                         vld;
  logic [squad_pkg::HORNER_LAT-1:0]   vld_dly;
  logic                               s7_vld;

  // stage 0: input word
  logic signed [squad_pkg::COORD_W-1:0] s0_pos_x, s0_pos_y, s0_ox, s0_oy;
  logic [squad_pkg::SIZE_W-1:0]         s0_w, s0_h;
  logic signed [squad_pkg::SCALE_W-1:0] s0_sx, s0_sy;
  logic [squad_pkg::ANGLE_W-1:0]        s0_angle;

  // stage 1: products and quadrant
  logic signed [squad_pkg::SCALED_W-1:0] s1_pw, s1_ph, s1_pox, s1_poy;
  logic signed [squad_pkg::COORD_W-1:0]  s1_pos_x, s1_pos_y;
  logic [squad_pkg::REM_W-1:0]           s1_rem;
  logic [1:0]                            s1_quad;
  logic [2:0]                            quad_idx;
  logic [squad_pkg::ANGLE_W-1:0]         quad_base;

  // stages 2 to 6
  geo_t                                  s2_geo, s3_geo, s4_geo, s5_geo;
  logic [30:0]                           s2_ax, s3_ax, s4_ax;
  logic [25:0]                           s2_m1;
  logic [17:0]                           s3_m;
  logic [36:0]                           s3_mr;
  logic [12:0]                           s4_qc;
  logic [squad_pkg::X_W-1:0]             s5_x;
  side_t                                 s6_side;
  logic [31:0]                           s6_x2;

  // stage 2 helpers
  logic signed [squad_pkg::SCALED_W-1:0] rnd_w, rnd_h, rnd_ox, rnd_oy;
  logic signed [squad_pkg::GEO_W-1:0]    sw, sh, offx, offy;
  // stage 4 helpers
  logic [12:0]                           q0;
  logic [18:0]                           r45;
  // stage 6 helpers
  logic [61:0]                           xsq;

  // delay line beside the taylor lanes
  side_t                                 side_dly [squad_pkg::HORNER_LAT];
  logic [squad_pkg::X_W-1:0]             t_sin, t_cos;

  // trig finish
  logic [31:0]                           s7_sq;
  logic [squad_pkg::X_W-1:0]             s7_cq;
  geo_t                                  s7_geo;
  logic [61:0]                           sq_prod;
  logic [32:0]                           sv_rnd, cv_rnd;
  logic signed [squad_pkg::TRIG_W-1:0]   sv, cv;

  // valid shift
  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      vld_dly <= '0;
      s7_vld  <= 1'b0;
      item_vld <= 1'b0;
    end else begin
      vld      <= {vld[5:0], take};
      vld_dly  <= {vld_dly[squad_pkg::HORNER_LAT-2:0], vld[6]};
      s7_vld   <= vld_dly[squad_pkg::HORNER_LAT-1];
      item_vld <= s7_vld;
    end
  end

  // stage 0: capture the word
  always_ff @(posedge clk) begin
    if (take) begin
      s0_pos_x <= pos_x;
      s0_pos_y <= pos_y;
      s0_w     <= size_w;
      s0_h     <= size_h;
      s0_sx    <= scale_x;
      s0_sy    <= scale_y;
      s0_ox    <= origin_x;
      s0_oy    <= origin_y;
      s0_angle <= angle_deg;
    end
  end

  // quadrant count by compare
  always_comb begin
    quad_idx = '0;
    for (int i = 1; i <= 5; i++) begin
      if (s0_angle >= squad_pkg::ANGLE_W'(i * squad_pkg::QUAD_UNITS)) quad_idx = 3'(i);
    end
    unique case (quad_idx)
      3'd0:    quad_base = '0;
      3'd1:    quad_base = squad_pkg::ANGLE_W'(1 * squad_pkg::QUAD_UNITS);
      3'd2:    quad_base = squad_pkg::ANGLE_W'(2 * squad_pkg::QUAD_UNITS);
      3'd3:    quad_base = squad_pkg::ANGLE_W'(3 * squad_pkg::QUAD_UNITS);
      3'd4:    quad_base = squad_pkg::ANGLE_W'(4 * squad_pkg::QUAD_UNITS);
      3'd5:    quad_base = squad_pkg::ANGLE_W'(5 * squad_pkg::QUAD_UNITS);
      default: quad_base = '0;
    endcase
  end

  // stage 1: scale products, angle remainder
  always_ff @(posedge clk) begin
    s1_pw    <= squad_pkg::SCALED_W'($signed({1'b0, s0_w})) * squad_pkg::SCALED_W'(s0_sx);
    s1_ph    <= squad_pkg::SCALED_W'($signed({1'b0, s0_h})) * squad_pkg::SCALED_W'(s0_sy);
    s1_pox   <= squad_pkg::SCALED_W'(s0_ox) * squad_pkg::SCALED_W'(s0_sx);
    s1_poy   <= squad_pkg::SCALED_W'(s0_oy) * squad_pkg::SCALED_W'(s0_sy);
    s1_pos_x <= s0_pos_x;
    s1_pos_y <= s0_pos_y;
    s1_rem   <= squad_pkg::REM_W'(s0_angle - quad_base);
    s1_quad  <= quad_idx[1:0];
  end

  // round the scaled terms to q16.8
  always_comb begin
    rnd_w  = s1_pw + squad_pkg::SCALED_W'(128);
    rnd_h  = s1_ph + squad_pkg::SCALED_W'(128);
    rnd_ox = s1_pox + squad_pkg::SCALED_W'(128);
    rnd_oy = s1_poy + squad_pkg::SCALED_W'(128);
    sw   = squad_pkg::GEO_W'($signed(rnd_w[squad_pkg::SCALED_W-1:8]));
    sh   = squad_pkg::GEO_W'($signed(rnd_h[squad_pkg::SCALED_W-1:8]));
    offx = squad_pkg::GEO_W'($signed(rnd_ox[squad_pkg::SCALED_W-1:8]));
    offy = squad_pkg::GEO_W'($signed(rnd_oy[squad_pkg::SCALED_W-1:8]));
  end

  // stage 2: corner offsets, angle in radians split in two products
  always_ff @(posedge clk) begin
    s2_geo.quad  <= s1_quad;
    s2_geo.pos_x <= s1_pos_x;
    s2_geo.pos_y <= s1_pos_y;
    s2_geo.cx0   <= -offx;
    s2_geo.cx1   <= sw - offx;
    s2_geo.cy0   <= -offy;
    s2_geo.cy1   <= sh - offy;
    s2_ax <= 31'(32'(s1_rem) * 32'(squad_pkg::PI_HI));
    s2_m1 <= 26'(26'(s1_rem) * 26'(squad_pkg::PI_LO) + 26'(squad_pkg::QUAD_UNITS));
  end

  // stage 3: low part over 11520 by reciprocal
  always_ff @(posedge clk) begin
    s3_geo <= s2_geo;
    s3_ax  <= s2_ax;
    s3_m   <= s2_m1[25:8];
    s3_mr  <= 37'(s2_m1[25:8]) * 37'(squad_pkg::RECIP_45);
  end

  // stage 4: correct the quotient
  assign q0  = s3_mr[36:24];
  assign r45 = 19'(s3_m) - 19'(q0) * 19'(45);
  always_ff @(posedge clk) begin
    s4_geo <= s3_geo;
    s4_ax  <= s3_ax;
    s4_qc  <= (r45 >= 19'(45)) ? q0 + 13'd1 : q0;
  end

  // stage 5: radians in q30
  always_ff @(posedge clk) begin
    s5_geo <= s4_geo;
    s5_x   <= s4_ax + squad_pkg::X_W'(s4_qc);
  end

  // stage 6: square of the angle
  assign xsq = 62'(s5_x) * 62'(s5_x);
  always_ff @(posedge clk) begin
    s6_side.geo <= s5_geo;
    s6_side.x   <= s5_x;
    s6_x2       <= xsq[61:30];
  end

  // taylor lanes
  squad_horner u_sin (
    .clk      (clk),
    .lane_cos (1'b0),
    .x2       (s6_x2),
    .t_out    (t_sin)
  );

  squad_horner u_cos (
    .clk      (clk),
    .lane_cos (1'b1),
    .x2       (s6_x2),
    .t_out    (t_cos)
  );

  // side data waits for the lanes
  always_ff @(posedge clk) begin
    side_dly[0] <= s6_side;
    for (int i = 1; i < squad_pkg::HORNER_LAT; i++) side_dly[i] <= side_dly[i-1];
  end

  // sine series times x
  assign sq_prod = 62'(side_dly[squad_pkg::HORNER_LAT-1].x) * 62'(t_sin);
  always_ff @(posedge clk) begin
    s7_sq  <= sq_prod[61:30];
    s7_cq  <= t_cos;
    s7_geo <= side_dly[squad_pkg::HORNER_LAT-1].geo;
  end

  // round to trig precision and fold the quadrant
  always_comb begin
    sv_rnd = 33'(s7_sq) + (33'(1) << (squad_pkg::TRIG_SHIFT - 1));
    cv_rnd = 33'(s7_cq) + (33'(1) << (squad_pkg::TRIG_SHIFT - 1));
    sv = $signed({1'b0, squad_pkg::TRIG_MAG_W'(sv_rnd >> squad_pkg::TRIG_SHIFT)});
    cv = $signed({1'b0, squad_pkg::TRIG_MAG_W'(cv_rnd >> squad_pkg::TRIG_SHIFT)});
  end

  always_ff @(posedge clk) begin
    item.pos_x <= s7_geo.pos_x;
    item.pos_y <= s7_geo.pos_y;
    item.cx0   <= s7_geo.cx0;
    item.cx1   <= s7_geo.cx1;
    item.cy0   <= s7_geo.cy0;
    item.cy1   <= s7_geo.cy1;
    unique case (s7_geo.quad)
      2'd0: begin
        item.sin_v <= sv;
        item.cos_v <= cv;
      end
      2'd1: begin
        item.sin_v <= cv;
        item.cos_v <= -sv;
      end
      2'd2: begin
        item.sin_v <= -sv;
        item.cos_v <= -cv;
      end
      2'd3: begin
        item.sin_v <= -cv;
        item.cos_v <= sv;
      end
    endcase
  end

endmodule

@@ rtl/squad_item_fifo.sv @@
// Queue of prepared sprites between the front pipeline and the corner unit.
// Depends on squad_pkg for the item type and depth.
`timescale 1ns / 1ps

module squad_item_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  squad_pkg::item_t   wr_item,
  input  logic               rd_en,
  output logic               rd_vld,
  output squad_pkg::item_t   rd_item
);

  squad_pkg::item_t                mem [squad_pkg::QDEPTH];
  logic [squad_pkg::QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [squad_pkg::QCNT_W-1:0]    count;

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_item;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      count <= count + squad_pkg::QCNT_W'(wr_en) - squad_pkg::QCNT_W'(rd_en);
    end
  end

  assign rd_vld  = (count != '0);
  assign rd_item = mem[rd_ptr];

endmodule

@@ rtl/squad_back.sv @@
// Corner unit: walks the four corners of each sprite, rotates and offsets
// them, and queues the vertex words. Depends on squad_pkg.
`timescale 1ns / 1ps

module squad_back (
  input  logic                 clk,
  input  logic                 rst,
  input  squad_pkg::region_t   region,
  input  logic                 item_vld,
  input  squad_pkg::item_t     item,
  output logic                 item_pop,
  input  logic                 res_pop,
  output logic                 res_empty,
  output squad_pkg::result_t   res
);

  localparam logic signed [squad_pkg::SUM_W-1:0] RND_HALF =
    squad_pkg::SUM_W'(1) << (squad_pkg::TRIG_BITS - 1);
  localparam logic signed [squad_pkg::POS_SUM_W-1:0] VMAX =
    squad_pkg::POS_SUM_W'(8388607);
  localparam logic signed [squad_pkg::POS_SUM_W-1:0] VMIN =
    -squad_pkg::POS_SUM_W'(8388608);

  logic [1:0]                           corner;
  logic                                 issue;
  logic [squad_pkg::RCNT_W-1:0]         used;
  logic                                 res_take;
  logic                                 y_far;
  logic signed [squad_pkg::GEO_W-1:0]   cx_sel, cy_sel;

  // issue stage
  logic                                 b1_vld;
  logic signed [squad_pkg::PROD_W-1:0]  b1_pxc, b1_pys, b1_pxs, b1_pyc;
  logic signed [squad_pkg::COORD_W-1:0] b1_pos_x, b1_pos_y;
  logic [1:0]                           b1_corner;
  logic [squad_pkg::UV_W-1:0]           b1_u, b1_v;

  // sum stage
  logic                                 b2_vld;
  logic signed [squad_pkg::SUM_W-1:0]   b2_rx, b2_ry;
  logic signed [squad_pkg::COORD_W-1:0] b2_pos_x, b2_pos_y;
  logic [1:0]                           b2_corner;
  logic [squad_pkg::UV_W-1:0]           b2_u, b2_v;

  // finish stage
  logic                                 b3_vld;
  squad_pkg::result_t                   b3_res;
  logic signed [squad_pkg::SUM_W-1:0]   rx_rnd, ry_rnd;
  logic signed [squad_pkg::ROT_W-1:0]   rx, ry;
  logic signed [squad_pkg::POS_SUM_W-1:0] sum_x, sum_y;

  // result queue
  squad_pkg::result_t                   mem [squad_pkg::RDEPTH];
  logic [squad_pkg::RPTR_W-1:0]         wr_ptr, rd_ptr;
  logic [squad_pkg::RCNT_W-1:0]         count;

  function automatic logic signed [squad_pkg::COORD_W-1:0] sat24(
    input logic signed [squad_pkg::POS_SUM_W-1:0] v
  );
    logic signed [squad_pkg::COORD_W-1:0] r;
    if (v > VMAX) r = VMAX[squad_pkg::COORD_W-1:0];
    else if (v < VMIN) r = VMIN[squad_pkg::COORD_W-1:0];
    else r = v[squad_pkg::COORD_W-1:0];
    return r;
  endfunction

  // issue a corner only when the result queue has room for it
  assign res_take = res_pop && !res_empty;
  assign issue    = item_vld && (used < squad_pkg::RCNT_W'(squad_pkg::RDEPTH));
  assign item_pop = issue && (corner == squad_pkg::CORNER_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      corner <= squad_pkg::CORNER_FIRST;
      used   <= '0;
    end else begin
      if (issue) corner <= corner + 2'd1;
      used <= used + squad_pkg::RCNT_W'(issue) - squad_pkg::RCNT_W'(res_take);
    end
  end

  // corner select: corners 2 and 3 use the width, 1 and 2 the height
  assign y_far  = corner[1] ^ corner[0];
  assign cx_sel = corner[1] ? item.cx1 : item.cx0;
  assign cy_sel = y_far ? item.cy1 : item.cy0;

  // rotation products
  always_ff @(posedge clk) begin
    b1_pxc    <= squad_pkg::PROD_W'(cx_sel) * squad_pkg::PROD_W'(item.cos_v);
    b1_pys    <= squad_pkg::PROD_W'(cy_sel) * squad_pkg::PROD_W'(item.sin_v);
    b1_pxs    <= squad_pkg::PROD_W'(cx_sel) * squad_pkg::PROD_W'(item.sin_v);
    b1_pyc    <= squad_pkg::PROD_W'(cy_sel) * squad_pkg::PROD_W'(item.cos_v);
    b1_pos_x  <= item.pos_x;
    b1_pos_y  <= item.pos_y;
    b1_corner <= corner;
    b1_u      <= corner[1] ? region.u_right : region.u_left;
    b1_v      <= y_far ? region.v_top : region.v_bottom;
  end

  // rotated sums
  always_ff @(posedge clk) begin
    b2_rx     <= squad_pkg::SUM_W'(b1_pxc) - squad_pkg::SUM_W'(b1_pys);
    b2_ry     <= squad_pkg::SUM_W'(b1_pxs) + squad_pkg::SUM_W'(b1_pyc);
    b2_pos_x  <= b1_pos_x;
    b2_pos_y  <= b1_pos_y;
    b2_corner <= b1_corner;
    b2_u      <= b1_u;
    b2_v      <= b1_v;
  end

  // round, add position, saturate
  always_comb begin
    rx_rnd = b2_rx + RND_HALF;
    ry_rnd = b2_ry + RND_HALF;
    rx = rx_rnd[squad_pkg::SUM_W-1:squad_pkg::TRIG_BITS];
    ry = ry_rnd[squad_pkg::SUM_W-1:squad_pkg::TRIG_BITS];
    sum_x = squad_pkg::POS_SUM_W'(rx) + squad_pkg::POS_SUM_W'(b2_pos_x);
    sum_y = squad_pkg::POS_SUM_W'(ry) + squad_pkg::POS_SUM_W'(b2_pos_y);
  end

  always_ff @(posedge clk) begin
    b3_res.corner      <= b2_corner;
    b3_res.vert_x      <= sat24(sum_x);
    b3_res.vert_y      <= sat24(sum_y);
    b3_res.tex_u       <= b2_u;
    b3_res.tex_v       <= b2_v;
    b3_res.last_vertex <= (b2_corner == squad_pkg::CORNER_LAST);
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_vld <= 1'b0;
      b2_vld <= 1'b0;
      b3_vld <= 1'b0;
    end else begin
      b1_vld <= issue;
      b2_vld <= b1_vld;
      b3_vld <= b2_vld;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (b3_vld) mem[wr_ptr] <= b3_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (b3_vld) wr_ptr <= wr_ptr + 1'b1;
      if (res_take) rd_ptr <= rd_ptr + 1'b1;
      count <= count + squad_pkg::RCNT_W'(b3_vld) - squad_pkg::RCNT_W'(res_take);
    end
  end

  assign res_empty = (count == '0);
  assign res       = mem[rd_ptr];

endmodule

@@ rtl/squad_checker.sv @@
// Port checks for the sprite quad transform, bound to the top level.
// Depends on squad_pkg for the corner codes.
`timescale 1ns / 1ps

module squad_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [1:0] corner,
  input logic       last_vertex
);

  // reset leaves no vertex waiting
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("vertex queue not empty after reset");

  // last flag marks exactly the fourth corner
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (last_vertex == (corner == squad_pkg::CORNER_LAST)))
    else $error("last_vertex does not match corner");

  // corners leave in order, wrapping after the fourth
  a_corner_order: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty) |=> (empty || (corner == $past(corner) + 2'd1)))
    else $error("corner out of order");

  // a waiting vertex holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(corner)))
    else $error("waiting vertex changed");

endmodule

bind sprite_quad_transform squad_checker u_squad_checker (.*);
